/* hdl/dfs_connected_component_count_defines.svh */
// Assertion macros shared by the RTL of the component counter.
`ifndef DFS_CONNECTED_COMPONENT_COUNT_DEFINES_SVH
`define DFS_CONNECTED_COMPONENT_COUNT_DEFINES_SVH

`ifndef ASSERT_OFF

// Combinational invariant, checked at every rising clock edge out of reset.
`define DFSCC_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Same-cycle implication.
`define DFSCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define DFSCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DFSCC_ASSERT(lbl, clk, rst_n, expr)
`define DFSCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DFSCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/dfscc_pkg.sv */
// Types and constants shared by the component counter modules.
package dfscc_pkg;

    localparam int ACTION_W = 2;
    localparam int VTX_W    = 6;
    localparam int CNT_W    = 7;

    localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;

    // Cursor unit control: which cursor, and what to do with it.
    typedef struct packed {
        logic sel_nbr;
        logic clear;
        logic step;
    } t_cur_ctl;

endpackage

/* hdl/dfscc_ram.sv */
// Generic simple dual-port RAM with registered read.
module dfscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/dfscc_cursor.sv */
// Shared scan cursor unit: start-vertex and neighbor cursors, one incrementer and limit compare.
module dfscc_cursor #(
    parameter int CW = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dfscc_pkg::t_cur_ctl  i_ctl,
    input  logic [CW-1:0]        i_limit,
    output logic [CW-1:0]        o_index,
    output logic                 o_at_end
);
    import dfscc_pkg::*;

    logic [CW-1:0] r_start_cur, n_start_cur;
    logic [CW-1:0] r_nbr_cur,   n_nbr_cur;
    logic [CW-1:0] sel_cur;
    logic [CW-1:0] sel_inc;

    assign sel_cur  = i_ctl.sel_nbr ? r_nbr_cur : r_start_cur;
    assign sel_inc  = sel_cur + 1'b1;
    assign o_index  = sel_cur;
    assign o_at_end = (sel_cur >= i_limit);

    always_comb begin
        n_start_cur = r_start_cur;
        n_nbr_cur   = r_nbr_cur;
        if (i_ctl.clear) begin
            if (i_ctl.sel_nbr) n_nbr_cur = '0;
            else               n_start_cur = '0;
        end else if (i_ctl.step) begin
            if (i_ctl.sel_nbr) n_nbr_cur = sel_inc;
            else               n_start_cur = sel_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_cur <= '0;
            r_nbr_cur   <= '0;
        end else begin
            r_start_cur <= n_start_cur;
            r_nbr_cur   <= n_nbr_cur;
        end
    end

endmodule

/* hdl/dfs_connected_component_count.sv */
// Top level: edge store, depth-first walk sequencer and component count.
//
//  channel   dir  handshake                    payload
//  -------   ---  ---------------------------  ------------------------------------
//  input     in   i_in_valid / o_in_ready      i_action, i_edge_source, i_edge_target
//  result    out  o_out_valid / i_out_ready    o_component_count
//  config    in   i_cfg_wr_en                  i_cfg_wr_data (vertex_count)
//
// Add edge: row read on acceptance in S_IDLE, then write back in S_ADD; a dropped
// edge, clear and unused codes are handled in S_IDLE alone.
// Count: the single cursor unit tests one bit per cycle, for each row and for the
// start scan, which pauses while each walk runs.
// Reset (synchronous) empties the graph at once through per-row valid bits.
// o_in_ready is low while an add or count is in progress; a finished count
// waits in the output register for i_out_ready.
`include "dfs_connected_component_count_defines.svh"

module dfs_connected_component_count #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [dfscc_pkg::ACTION_W-1:0] i_action,
    input  logic [dfscc_pkg::VTX_W-1:0]    i_edge_source,
    input  logic [dfscc_pkg::VTX_W-1:0]    i_edge_target,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [dfscc_pkg::CNT_W-1:0]    o_component_count,
    input  logic                           i_cfg_wr_en,
    input  logic [dfscc_pkg::CNT_W-1:0]    i_cfg_wr_data
);
    import dfscc_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_POP  = 3'd3;
    localparam logic [2:0] S_STK  = 3'd4;
    localparam logic [2:0] S_ROW  = 3'd5;
    localparam logic [2:0] S_EXP  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_vertex_count;
    logic [MAX_VERTICES-1:0] r_row_valid, n_row_valid;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [MAX_VERTICES-1:0] r_fresh, n_fresh;
    logic [CW-1:0]           r_level, n_level;
    logic [CW-1:0]           r_walks, n_walks;
    logic [VW-1:0]           r_vtx, n_vtx;
    logic [VW-1:0]           r_src, n_src;
    logic [VW-1:0]           r_dst, n_dst;
    logic                    r_out_valid, n_out_valid;
    logic [CNT_W-1:0]        r_count, n_count;

    logic [CNT_W-1:0]        n_eff7;
    logic [CW-1:0]           n_lim;
    logic                    in_acc;
    logic                    run_acc;
    logic                    pop_empty;
    logic                    edge_ok;
    logic [CW-1:0]           lvl_dec;

    t_cur_ctl                cur_ctl;
    logic [CW-1:0]           cur_idx;
    logic                    cur_end;
    logic [VW-1:0]           cur_bit;

    logic                    adj_we;
    logic [VW-1:0]           adj_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
    logic                    stk_we;
    logic [VW-1:0]           stk_waddr;
    logic [VW-1:0]           stk_rdata;

    // effective vertex count, clamped to the store size
    assign n_eff7  = (r_vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                             : r_vertex_count;
    assign n_lim   = n_eff7[CW-1:0];
    assign edge_ok = ({1'b0, i_edge_source} < n_eff7) && ({1'b0, i_edge_target} < n_eff7);

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign run_acc    = in_acc && (i_action == ACT_RUN);
    assign pop_empty  = (r_state == S_POP) && (r_level == '0);
    assign lvl_dec    = r_level - 1'b1;
    assign cur_bit    = cur_idx[VW-1:0];

    assign adj_raddr  = (r_state == S_STK) ? stk_rdata : i_edge_source[VW-1:0];
    assign adj_wdata  = (r_row_valid[r_src] ? adj_rdata : '0)
                      | (MAX_VERTICES'(1) << r_dst);
    assign stk_waddr  = (r_state == S_SCAN) ? '0 : r_level[VW-1:0];

    always_comb begin
        n_state     = r_state;
        n_row_valid = r_row_valid;
        n_visited   = r_visited;
        n_fresh     = r_fresh;
        n_level     = r_level;
        n_walks     = r_walks;
        n_vtx       = r_vtx;
        n_src       = r_src;
        n_dst       = r_dst;
        n_out_valid = r_out_valid;
        n_count     = r_count;
        cur_ctl     = '0;
        adj_we      = 1'b0;
        stk_we      = 1'b0;

        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_action)
                        ACT_ADD: begin
                            if (edge_ok) begin
                                n_src   = i_edge_source[VW-1:0];
                                n_dst   = i_edge_target[VW-1:0];
                                n_state = S_ADD;
                            end
                        end
                        ACT_RUN: begin
                            n_visited     = '0;
                            n_walks       = '0;
                            n_level       = '0;
                            cur_ctl.clear = 1'b1;
                            n_state       = S_SCAN;
                        end
                        ACT_CLEAR: n_row_valid = '0;
                        default: ;
                    endcase
                end
            end
            S_ADD: begin
                adj_we             = 1'b1;
                n_row_valid[r_src] = 1'b1;
                n_state            = S_IDLE;
            end
            S_SCAN: begin
                if (cur_end) begin
                    n_state = S_DONE;
                end else begin
                    cur_ctl.step = 1'b1;
                    if (!r_visited[cur_bit]) begin
                        // new walk: mark and push the start vertex
                        n_visited[cur_bit] = 1'b1;
                        stk_we             = 1'b1;
                        n_level            = CW'(1);
                        n_walks            = r_walks + 1'b1;
                        n_state            = S_POP;
                    end
                end
            end
            S_POP: begin
                if (r_level == '0) begin
                    n_state = S_SCAN;
                end else begin
                    n_level = lvl_dec;
                    n_state = S_STK;
                end
            end
            S_STK: begin
                n_vtx   = stk_rdata;
                n_state = S_ROW;
            end
            S_ROW: begin
                n_fresh         = (r_row_valid[r_vtx] ? adj_rdata : '0) & ~r_visited;
                cur_ctl.sel_nbr = 1'b1;
                cur_ctl.clear   = 1'b1;
                n_state         = S_EXP;
            end
            S_EXP: begin
                cur_ctl.sel_nbr = 1'b1;
                if (cur_end) begin
                    n_state = S_POP;
                end else begin
                    cur_ctl.step = 1'b1;
                    if (r_fresh[cur_bit]) begin
                        n_visited[cur_bit] = 1'b1;
                        stk_we             = 1'b1;
                        n_level            = r_level + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_count     = CNT_W'(r_walks);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vertex_count <= VCOUNT_RESET;
            r_row_valid    <= '0;
            r_visited      <= '0;
            r_level        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
            r_visited   <= n_visited;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_vertex_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fresh <= n_fresh;
        r_walks <= n_walks;
        r_vtx   <= n_vtx;
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_count <= n_count;
    end

    dfscc_cursor #(
        .CW (CW)
    ) u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (cur_ctl),
        .i_limit  (n_lim),
        .o_index  (cur_idx),
        .o_at_end (cur_end)
    );

    dfscc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (r_src),
        .i_wdata (adj_wdata),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    dfscc_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (cur_bit),
        .i_raddr (lvl_dec[VW-1:0]),
        .o_rdata (stk_rdata)
    );

    assign o_out_valid       = r_out_valid;
    assign o_component_count = r_count;

    `DFSCC_ASSERT(a_level_bound, i_clk, i_rst_n, r_level <= n_lim)
    `DFSCC_ASSERT_NXT(a_run_starts_scan, i_clk, i_rst_n, run_acc, r_state == S_SCAN)
    `DFSCC_ASSERT_NXT(a_empty_stack_resumes, i_clk, i_rst_n, pop_empty, r_state == S_SCAN)
    `DFSCC_ASSERT_IMP(a_walks_bound, i_clk, i_rst_n, r_state == S_DONE, r_walks <= n_lim)

endmodule

/* dv/tb_dfs_connected_component_count.sv */
// Self-checking testbench for the depth-first component counter.
module tb_dfs_connected_component_count;
    timeunit 1ns;
    timeprecision 1ps;

    import dfscc_pkg::*;

    localparam int MAX_VTX = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES = 2500;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [VTX_W-1:0]    src;
        logic [VTX_W-1:0]    dst;
    } t_edge_cmd;

    typedef enum int {RX_FREE, RX_COIN, RX_PERIODIC, RX_SPARSE} t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic o_in_ready;
    logic [ACTION_W-1:0] action = '0;
    logic [VTX_W-1:0] edge_src = '0;
    logic [VTX_W-1:0] edge_dst = '0;
    logic o_out_valid;
    logic out_ready = 1'b0;
    logic [CNT_W-1:0] o_component_count;
    logic cfg_wr_en = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;

    // predictor state
    logic [MAX_VTX-1:0] adj_rows [MAX_VTX];
    logic [CNT_W-1:0] vcount;

    t_edge_cmd pending_cmds [$];
    logic [CNT_W-1:0] expected_counts [$];
    t_edge_cmd next_cmd;

    int errors = 0;
    int beats_in = 0;
    int counts_checked = 0;
    int settings_used = 0;
    int phase_idx = 0;
    int gap_left = 0;
    int burst_left = 0;
    int mode_left = 0;
    t_rx_mode rx_mode = RX_FREE;
    logic hold_off = 1'b0;

    dfs_connected_component_count #(
        .MAX_VERTICES(MAX_VTX)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (action),
        .i_edge_source    (edge_src),
        .i_edge_target    (edge_dst),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_component_count(o_component_count),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int eff_count();
        return (vcount > MAX_VTX) ? MAX_VTX : int'(vcount);
    endfunction

    // Number of walks a full scan over vertices 0..n-1 starts.
    function automatic logic [CNT_W-1:0] count_walks(int n);
        logic [MAX_VTX-1:0] mask;
        logic [MAX_VTX-1:0] seen;
        logic [MAX_VTX-1:0] fresh;
        logic [VTX_W-1:0] stk [MAX_VTX];
        logic [VTX_W-1:0] v;
        int sp;
        int walks;
        mask = (n >= MAX_VTX) ? '1 : ((64'd1 << n) - 64'd1);
        seen = '0;
        walks = 0;
        for (int s = 0; s < n; s++) begin
            if (!seen[s]) begin
                walks++;
                seen[s] = 1'b1;
                stk[0] = VTX_W'(s);
                sp = 1;
                while (sp > 0) begin
                    sp--;
                    v = stk[sp];
                    fresh = adj_rows[v] & mask & ~seen;
                    for (int j = 0; j < MAX_VTX; j++) begin
                        if (fresh[j]) begin
                            seen[j] = 1'b1;
                            stk[sp] = VTX_W'(j);
                            sp++;
                        end
                    end
                end
            end
        end
        return CNT_W'(walks);
    endfunction

    function automatic void apply_cmd(logic [ACTION_W-1:0] a, logic [VTX_W-1:0] s,
                                      logic [VTX_W-1:0] d);
        int n;
        n = eff_count();
        case (a)
            ACT_ADD: begin
                if (int'(s) < n && int'(d) < n) adj_rows[s][d] = 1'b1;
            end
            ACT_RUN: begin
                expected_counts.push_back(count_walks(n));
            end
            ACT_CLEAR: begin
                foreach (adj_rows[i]) adj_rows[i] = '0;
            end
            default: begin
            end
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // driver: bursts of beats separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else if (!in_valid || o_in_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                next_cmd = pending_cmds.pop_front();
                action <= next_cmd.action;
                edge_src <= next_cmd.src;
                edge_dst <= next_cmd.dst;
                in_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                               : $urandom_range(0, 8);
                    gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches mode every so often
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            mode_left <= 0;
        end else begin
            if (mode_left == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(16, 128);
            end else begin
                mode_left <= mode_left - 1;
            end
            if (hold_off) begin
                out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_FREE:     out_ready <= 1'b1;
                    RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: out_ready <= (mode_left % 4 == 0);
                    default:     out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // monitor: predict on accepted input beats, check accepted result beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                apply_cmd(action, edge_src, edge_dst);
                beats_in++;
            end
            if (o_out_valid && out_ready) begin
                if (expected_counts.size() == 0) begin
                    report_mismatch($sformatf("result %0d with none expected",
                                              o_component_count));
                end else begin
                    if (o_component_count !== expected_counts[0])
                        report_mismatch($sformatf("component_count %0d, expected %0d",
                                                  o_component_count, expected_counts[0]));
                    void'(expected_counts.pop_front());
                end
                counts_checked++;
            end
        end
    end

    task automatic push_cmd(logic [ACTION_W-1:0] a, logic [VTX_W-1:0] s,
                            logic [VTX_W-1:0] d);
        t_edge_cmd c;
        c.action = a;
        c.src = s;
        c.dst = d;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || in_valid || expected_counts.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_vertex_count(logic [CNT_W-1:0] v);
        wait_idle();
        @(posedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        vcount = v;
        settings_used++;
    endtask

    // Graph-building sequences: optional clear, a batch of edges with occasional unused codes, then a count.
    task automatic random_phase(int n_items);
        int n;
        int issued;
        int k;
        n = eff_count();
        issued = 0;
        while (issued < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                push_cmd(ACT_CLEAR, VTX_W'($urandom), VTX_W'($urandom));
                issued++;
            end
            k = $urandom_range(0, (n * 2 > 40) ? 40 : n * 2 + 1);
            repeat (k) begin
                if (n == 0 || $urandom_range(0, 9) == 0)
                    push_cmd(ACT_ADD, VTX_W'($urandom), VTX_W'($urandom));
                else
                    push_cmd(ACT_ADD, VTX_W'($urandom_range(0, n - 1)),
                             VTX_W'($urandom_range(0, n - 1)));
                issued++;
                if ($urandom_range(0, 19) == 0)
                    push_cmd(ACT_UNUSED, VTX_W'($urandom), VTX_W'($urandom));
            end
            push_cmd(ACT_RUN, VTX_W'($urandom), VTX_W'($urandom));
            issued++;
        end
    endtask

    initial begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
        vcount = VCOUNT_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full size
        set_vertex_count(7'd64);
        push_cmd(ACT_RUN, 6'd0, 6'd0);
        push_cmd(ACT_ADD, 6'd0, 6'd63);
        push_cmd(ACT_ADD, 6'd63, 6'd0);
        push_cmd(ACT_ADD, 6'd63, 6'd63);
        push_cmd(ACT_ADD, 6'd0, 6'd63);
        push_cmd(ACT_RUN, 6'd63, 6'd63);
        push_cmd(ACT_CLEAR, 6'd21, 6'd42);
        push_cmd(ACT_RUN, 6'd0, 6'd0);
        // zero vertices: edges dropped, count is zero
        set_vertex_count(7'd0);
        push_cmd(ACT_ADD, 6'd0, 6'd0);
        push_cmd(ACT_RUN, 6'd0, 6'd0);
        // oversized count saturates; unused code ignored
        set_vertex_count(7'd127);
        push_cmd(ACT_ADD, 6'd5, 6'd6);
        push_cmd(ACT_UNUSED, 6'd63, 6'd63);
        push_cmd(ACT_RUN, 6'd0, 6'd0);
        // out of range edge, then stale edges after shrinking
        set_vertex_count(7'd4);
        push_cmd(ACT_ADD, 6'd3, 6'd4);
        push_cmd(ACT_ADD, 6'd3, 6'd0);
        push_cmd(ACT_ADD, 6'd1, 6'd2);
        push_cmd(ACT_RUN, 6'd0, 6'd0);
        set_vertex_count(7'd2);
        push_cmd(ACT_RUN, 6'd0, 6'd0);
        set_vertex_count(7'd1);
        push_cmd(ACT_RUN, 6'd0, 6'd0);
        push_cmd(ACT_CLEAR, 6'd0, 6'd0);

        // random
        phase_idx = 1;
        set_vertex_count(7'd3);
        random_phase(110);
        phase_idx = 2;
        set_vertex_count(7'd10);
        random_phase(130);
        phase_idx = 3;
        set_vertex_count(7'd64);
        random_phase(110);
        phase_idx = 4;
        set_vertex_count(7'd1);
        random_phase(60);
        phase_idx = 5;
        set_vertex_count(7'd0);
        random_phase(40);
        phase_idx = 6;
        set_vertex_count(CNT_W'($urandom_range(2, 16)));
        random_phase(150);
        phase_idx = 7;
        set_vertex_count(CNT_W'($urandom_range(65, 127)));
        random_phase(100);
        phase_idx = 8;
        set_vertex_count(7'd6);
        random_phase(150);
        phase_idx = 9;
        set_vertex_count(7'd16);
        random_phase(150);

        wait_idle();
        $display("ran %0d input beats and checked %0d counts", beats_in, counts_checked);
        $display("over %0d vertex-count settings, including 0, 1, 64 and oversized",
                 settings_used);
        if (errors == 0 && expected_counts.size() == 0) begin
            $display("dfs_connected_component_count: match");
        end else begin
            $display("dfs_connected_component_count: mismatch");
        end
        $finish;
    end

    // long receiver hold-off so the output register fills and input stalls
    initial begin
        wait (phase_idx == 2);
        repeat (20) @(negedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #200_000_000;
        $display("timeout waiting for the run to finish");
        $display("dfs_connected_component_count: mismatch");
        $finish;
    end

endmodule
